// ----- design/cmc_pkg.sv -----
// ----------------------------------------------------------------------------
// cmc_pkg: shared types and constants of the column mean centroid block
// Holds the transfer payload structs, the divider request and response, and
// the widths of the column sums and the row counter.
// ----------------------------------------------------------------------------
package cmc_pkg;

    localparam int MAX_COLS      = 16;
    localparam int COL_IDX_W     = $clog2(MAX_COLS);
    localparam int COL_CNT_W     = 5;
    localparam int MAX_ROWS_LOG2 = 20;
    localparam int ROW_CNT_W     = MAX_ROWS_LOG2 + 1;
    localparam int SAMPLE_BITS   = 24;
    localparam int SUM_W         = 44;
    localparam int DIV_STEP_W    = $clog2(SUM_W);
    localparam logic [COL_CNT_W-1:0] COL_COUNT_RESET = COL_CNT_W'(15);

    typedef logic [COL_CNT_W-1:0] col_count_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          final_row;
    } in_item_t;

    typedef struct packed {
        logic [COL_IDX_W-1:0]          column_index;
        logic signed [SAMPLE_BITS-1:0] mean;
        logic                          overflow;
        logic                          last;
    } out_item_t;

    typedef struct packed {
        logic                    start;
        logic signed [SUM_W-1:0] dividend;
        logic [ROW_CNT_W-1:0]    divisor;
    } div_req_t;

    typedef struct packed {
        logic                          busy;
        logic                          done;
        logic signed [SAMPLE_BITS-1:0] quotient;
    } div_rsp_t;

endpackage

// ----- design/cmc_divider.sv -----
// ----------------------------------------------------------------------------
// cmc_divider: iterative signed divider, one quotient bit per cycle
// Divides a signed column sum by the unsigned row count with restoring
// division on the magnitude, truncating toward zero. The result is held
// with done high until the next start.
// ----------------------------------------------------------------------------
module cmc_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  cmc_pkg::div_req_t req,
    output cmc_pkg::div_rsp_t rsp
);
    import cmc_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } div_state_t;

    div_state_t              state_reg, state_next;
    logic                    done_reg, done_next;
    logic [DIV_STEP_W-1:0]   step_reg, step_next;
    logic [SUM_W-1:0]        mag_reg, mag_next;
    logic [ROW_CNT_W-1:0]    rem_reg, rem_next;
    logic [ROW_CNT_W-1:0]    divisor_reg, divisor_next;
    logic                    neg_reg, neg_next;
    logic [ROW_CNT_W:0]      trial;
    logic                    fits;
    logic [SUM_W-1:0]        q_full;

    // Shift the next dividend bit into the partial remainder and compare
    assign trial = {rem_reg, mag_reg[SUM_W-1]};
    assign fits  = trial >= {1'b0, divisor_reg};

    always_comb
    begin
        state_next   = state_reg;
        done_next    = done_reg;
        step_next    = step_reg;
        mag_next     = mag_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        neg_next     = neg_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.start)
                begin
                    neg_next     = req.dividend[SUM_W-1];
                    mag_next     = req.dividend[SUM_W-1] ? (SUM_W'(0) - SUM_W'(req.dividend))
                                                         : SUM_W'(req.dividend);
                    rem_next     = '0;
                    step_next    = '0;
                    divisor_next = req.divisor;
                    done_next    = 1'b0;
                    state_next   = ST_RUN;
                end
            end
            ST_RUN:
            begin
                // Restore or keep the remainder, shift in the quotient bit
                rem_next  = fits ? ROW_CNT_W'(trial - {1'b0, divisor_reg})
                                 : trial[ROW_CNT_W-1:0];
                mag_next  = {mag_reg[SUM_W-2:0], fits};
                step_next = step_reg + DIV_STEP_W'(1);
                if (step_reg == DIV_STEP_W'(SUM_W - 1))
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold sequencer state and the done flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            step_reg  <= step_next;
        end
    end

    // Hold the datapath
    always_ff @(posedge clk)
    begin
        mag_reg     <= mag_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        neg_reg     <= neg_next;
    end

    // Apply the sign to the magnitude quotient
    assign q_full       = neg_reg ? (SUM_W'(0) - mag_reg) : mag_reg;
    assign rsp.quotient = q_full[SAMPLE_BITS-1:0];
    assign rsp.done     = done_reg;
    assign rsp.busy     = (state_reg == ST_RUN);

endmodule

// ----- design/column_mean_centroid_top.sv -----
// ----------------------------------------------------------------------------
// column_mean_centroid_top: per-column mean of a set of vectors
// Accumulates row-major samples into one wide sum per column and, at the end
// of a set, divides each sum by the row count and streams out the means.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one Q8.16 sample per transfer, row-major; final_row on the element
//           that ends a row marks that row as the last of the set.
//   out_* : one mean per column in column order, last set on the final one,
//           overflow set if rows beyond 2^20 were dropped from the set.
//   cfg_* : column_count, columns per row (0 acts as 1, above 16 as 16).
//           Always ready; write it only while the block is idle.
// Sequence:
//   Each sample is captured in ST_IDLE, then read, added and written back to
//   its column sum in ST_ACC. in_stall is high during ST_ACC.
//   At the end of a set each column runs through the shared bit-serial
//   divider: a start state, one step for each of the 44 quotient bits, then
//   the load of the output register.
// Reset clears all sums, the row count and the column position, and sets
// column_count to 15. A stalled output holds its mean; the sequencer waits
// before loading the next one. No memory clearing pass is needed.
// ----------------------------------------------------------------------------
module column_mean_centroid_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  cmc_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output cmc_pkg::out_item_t  out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  cmc_pkg::col_count_t cfg_data
);
    import cmc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIV_START,
        ST_DIV_WAIT
    } seq_state_t;

    localparam logic [ROW_CNT_W-1:0] ROW_LIMIT = ROW_CNT_W'(1) << MAX_ROWS_LOG2;

    seq_state_t              state_reg, state_next;
    col_count_t              col_count_reg, col_count_next;
    logic [COL_IDX_W-1:0]    pos_reg, pos_next;
    logic [COL_IDX_W-1:0]    div_col_reg, div_col_next;
    logic [ROW_CNT_W-1:0]    row_count_reg, row_count_next;
    logic                    dropped_reg, dropped_next;
    logic [MAX_COLS-1:0]     sum_valid_reg, sum_valid_next;
    logic                    out_valid_reg, out_valid_next;
    out_item_t               out_data_reg, out_data_next;
    in_item_t                item_reg;

    logic signed [SUM_W-1:0] sums [MAX_COLS];
    logic [COL_IDX_W-1:0]    sum_addr;
    logic signed [SUM_W-1:0] sum_rd;
    logic signed [SUM_W-1:0] sum_wdata;
    logic                    sum_we;

    col_count_t              cols_eff;
    logic                    row_open;
    logic                    row_end;
    logic                    col_end;
    logic                    out_free;
    logic                    out_load;
    logic                    in_xfer;
    div_req_t                div_req;
    div_rsp_t                div_rsp;

    assign in_xfer   = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    // Clamp the configured column count to the supported range
    always_comb
    begin
        if (col_count_reg == '0)
            cols_eff = COL_CNT_W'(1);
        else if (col_count_reg > COL_CNT_W'(MAX_COLS))
            cols_eff = COL_CNT_W'(MAX_COLS);
        else
            cols_eff = col_count_reg;
    end

    // Read one column sum; an entry never written this set reads as zero
    assign sum_addr  = (state_reg == ST_ACC) ? pos_reg : div_col_reg;
    assign sum_rd    = sum_valid_reg[sum_addr] ? sums[sum_addr] : '0;
    assign row_open  = (row_count_reg < ROW_LIMIT);
    assign sum_wdata = sum_rd + SUM_W'(item_reg.sample);
    assign sum_we    = (state_reg == ST_ACC) && row_open;
    assign row_end   = ({1'b0, pos_reg} + COL_CNT_W'(1)) >= cols_eff;
    assign col_end   = ({1'b0, div_col_reg} + COL_CNT_W'(1)) == cols_eff;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_load  = (state_reg == ST_DIV_WAIT) && div_rsp.done && out_free;

    // Drive the shared divider
    assign div_req.start    = (state_reg == ST_DIV_START);
    assign div_req.dividend = sum_rd;
    assign div_req.divisor  = row_count_reg;

    cmc_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Sequence accumulation and the end-of-set divisions
    always_comb
    begin
        state_next     = state_reg;
        col_count_next = col_count_reg;
        pos_next       = pos_reg;
        div_col_next   = div_col_reg;
        row_count_next = row_count_reg;
        dropped_next   = dropped_reg;
        sum_valid_next = sum_valid_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;

        if (cfg_valid && cfg_ready)
            col_count_next = cfg_data;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                    state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (row_open)
                    sum_valid_next[pos_reg] = 1'b1;
                else
                    dropped_next = 1'b1;
                if (!row_end)
                begin
                    pos_next   = pos_reg + COL_IDX_W'(1);
                    state_next = ST_IDLE;
                end
                else
                begin
                    pos_next = '0;
                    if (row_open)
                        row_count_next = row_count_reg + ROW_CNT_W'(1);
                    if (item_reg.final_row)
                    begin
                        div_col_next = '0;
                        state_next   = ST_DIV_START;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DIV_START:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (out_load)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.column_index = div_col_reg;
                    out_data_next.mean         = div_rsp.quotient;
                    out_data_next.overflow     = dropped_reg;
                    out_data_next.last         = col_end;
                    if (col_end)
                    begin
                        // Clear the set for the next one
                        sum_valid_next = '0;
                        row_count_next = '0;
                        dropped_next   = 1'b0;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        div_col_next = div_col_reg + COL_IDX_W'(1);
                        state_next   = ST_DIV_START;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold sequencer state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_count_reg <= COL_COUNT_RESET;
            pos_reg       <= '0;
            div_col_reg   <= '0;
            row_count_reg <= '0;
            dropped_reg   <= 1'b0;
            sum_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_count_reg <= col_count_next;
            pos_reg       <= pos_next;
            div_col_reg   <= div_col_next;
            row_count_reg <= row_count_next;
            dropped_reg   <= dropped_next;
            sum_valid_reg <= sum_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the input item and the output payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            item_reg <= in_data;
        out_data_reg <= out_data_next;
    end

    // Write back the column sum
    always_ff @(posedge clk)
    begin
        if (sum_we)
            sums[pos_reg] <= sum_wdata;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The row count never passes the row limit
    a_row_limit: assert property (@(posedge clk) disable iff (!rst_n)
        row_count_reg <= ROW_LIMIT)
        else $error("row count beyond limit");

    // Loading the last mean of a set leaves the set cleared
    a_set_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && col_end) |=> (row_count_reg == '0 && sum_valid_reg == '0))
        else $error("set not cleared after last mean");

    // The divider is only started while it is not running
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // A pending output is never overwritten before its transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !out_load)
        else $error("output overwritten while stalled");

endmodule

// ----- test/cmc_mean_checker.sv -----
// ----------------------------------------------------------------------------
// cmc_mean_checker: result checker for the column mean centroid block
// Watches the sample, result and column count transfers, keeps its own copy
// of the per-column sums and row count, queues the means each set should
// produce and compares every result transfer against the oldest one.
// ----------------------------------------------------------------------------
module cmc_mean_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  cmc_pkg::in_item_t   in_data,
    input  logic                out_valid,
    input  logic                out_stall,
    input  cmc_pkg::out_item_t  out_data,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  cmc_pkg::col_count_t cfg_data,
    output int                  fail_count,
    output int                  pend_count
);
    import cmc_pkg::*;

    localparam int MAX_PRINTED = 100;

    col_count_t              cols_cfg;
    logic signed [SUM_W-1:0] col_sum [MAX_COLS];
    logic [ROW_CNT_W-1:0]    row_total;
    logic [COL_IDX_W-1:0]    col_pos;
    logic                    rows_dropped;
    out_item_t               mean_q [$];
    out_item_t               want;
    int                      errs;

    // Clamp the column count register to the usable range
    function automatic int active_columns(col_count_t c);
        if (c == '0)
            return 1;
        if (c > MAX_COLS)
            return MAX_COLS;
        return int'(c);
    endfunction

    task automatic report(string msg);
        errs++;
        // keep the log short when the block is badly broken
        if (errs <= MAX_PRINTED)
            $display("mismatch: %s", msg);
    endtask

    task automatic clear_set();
        for (int i = 0; i < MAX_COLS; i++)
            col_sum[i] = '0;
        row_total    = '0;
        col_pos      = '0;
        rows_dropped = 1'b0;
    endtask

    // Add one sample to its column sum; on the end of a final row queue
    // one mean per column and start a new set
    task automatic absorb_sample(in_item_t item);
        int                      cols;
        int                      p;
        logic                    accept;
        logic signed [SUM_W-1:0] ext;
        longint                  q;
        out_item_t               r;
        cols   = active_columns(cols_cfg);
        p      = int'(col_pos);
        accept = (row_total < (ROW_CNT_W'(1) << MAX_ROWS_LOG2));
        if (accept)
        begin
            ext        = SUM_W'(item.sample);
            col_sum[p] = col_sum[p] + ext;
        end
        else
            rows_dropped = 1'b1;
        if (p + 1 < cols)
        begin
            col_pos = COL_IDX_W'(p + 1);
            return;
        end
        col_pos = '0;
        if (accept)
            row_total++;
        if (!item.final_row)
            return;
        for (int i = 0; i < cols; i++)
        begin
            // signed division in SystemVerilog truncates toward zero
            q              = longint'(col_sum[i]) / longint'(row_total);
            r.column_index = COL_IDX_W'(i);
            r.mean         = q[SAMPLE_BITS-1:0];
            r.overflow     = rows_dropped;
            r.last         = (i == cols - 1);
            mean_q.push_back(r);
        end
        clear_set();
    endtask

    // Track every transfer; results go first since they belong to older samples
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_cfg = COL_COUNT_RESET;
            clear_set();
            mean_q.delete();
            errs = 0;
            fail_count <= 0;
            pend_count <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (mean_q.size() == 0)
                    report($sformatf("result with nothing expected: column %0d mean %0d",
                                     out_data.column_index, out_data.mean));
                else
                begin
                    want = mean_q.pop_front();
                    if (out_data.column_index !== want.column_index)
                        report($sformatf("column_index got %0d expected %0d",
                                         out_data.column_index, want.column_index));
                    if (out_data.mean !== want.mean)
                        report($sformatf("column %0d mean got %0d expected %0d",
                                         want.column_index, out_data.mean, want.mean));
                    if (out_data.overflow !== want.overflow)
                        report($sformatf("column %0d overflow got %0b expected %0b",
                                         want.column_index, out_data.overflow,
                                         want.overflow));
                    if (out_data.last !== want.last)
                        report($sformatf("column %0d last got %0b expected %0b",
                                         want.column_index, out_data.last, want.last));
                end
            end
            if (cfg_valid && cfg_ready)
                cols_cfg = cfg_data;
            if (in_valid && !in_stall)
                absorb_sample(in_data);
            fail_count <= errs;
            pend_count <= mean_q.size();
        end
    end

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench top for the column mean centroid block
// Drives directed sets (column count extremes, truncation of negative means,
// ignored final flags, a column count change in the middle of a row), then
// random sets under three idling profiles, and gives the verdict from the
// checker's failure count.
// ----------------------------------------------------------------------------
module tb;
    import cmc_pkg::*;

    localparam int SETTLE      = 8;
    localparam int END_WAIT    = 100;
    localparam int QUIET_LIMIT = 3000;
    localparam int PHASE_ITEMS = 20;
    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    in_item_t   in_data;
    logic       out_valid;
    logic       out_stall;
    out_item_t  out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    col_count_t cfg_data;
    int         fail_count;
    int         pend_count;
    int         send_pct;
    int         recv_pct;
    int         quiet;
    int         span;
    int         sent;

    column_mean_centroid_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    cmc_mean_checker mean_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pend_count (pend_count)
    );

    initial clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Stall the result side at random
    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_pct);

    // End the run if no transfer happens for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet <= 0;
            else if (quiet >= QUIET_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
            else
                quiet <= quiet + 1;
        end
    end

    function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
        case ($urandom_range(0, 5))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return SAMPLE_BITS'($urandom_range(0, 16) - 8);
            default: return SAMPLE_BITS'($urandom());
        endcase
    endfunction

    function automatic col_count_t random_columns();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return col_count_t'(MAX_COLS);
            2:       return col_count_t'($urandom_range(MAX_COLS + 1, 31));
            default: return col_count_t'($urandom_range(1, 6));
        endcase
    endfunction

    // Idle at random, then hold the sample until it is taken
    task automatic send_sample(logic signed [SAMPLE_BITS-1:0] value, logic fin);
        while ($urandom_range(0, 99) < send_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{sample: value, final_row: fin};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
    endtask

    // Drop valid and wait until every expected mean has come out
    task automatic wait_idle(int extra);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pend_count != 0)
            @(posedge clk);
        repeat (extra)
            @(posedge clk);
    endtask

    task automatic write_columns(col_count_t value);
        wait_idle(SETTLE);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        span = (value == '0) ? 1 : (value > MAX_COLS) ? MAX_COLS : int'(value);
    endtask

    // One well-formed set: whole rows, final flag on the end of the last row,
    // noise flags on elements that do not end a row
    task automatic send_set();
        int   rows;
        logic fin;
        rows = (span > 8) ? 1 : $urandom_range(1, 3);
        for (int r = 0; r < rows; r++)
        begin
            for (int c = 0; c < span; c++)
            begin
                if (c == span - 1)
                    fin = (r == rows - 1);
                else
                    fin = 1'($urandom_range(0, 1));
                send_sample(random_sample(), fin);
            end
        end
    endtask

    task automatic run_phase(int s_pct, int r_pct, col_count_t first_cols);
        int start;
        send_pct = s_pct;
        recv_pct <= r_pct;
        write_columns(first_cols);
        start = sent;
        while (sent - start < PHASE_ITEMS)
        begin
            send_set();
            case ($urandom_range(0, 5))
                0:
                begin
                    // leave a row half done, then change the column count
                    if (span > 1)
                        repeat ($urandom_range(1, span - 1))
                            send_sample(random_sample(), 1'($urandom_range(0, 1)));
                    write_columns(random_columns());
                end
                1:       write_columns(random_columns());
                default: ;
            endcase
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        recv_pct  <= 47;
        send_pct  = 32;
        sent      = 0;
        span      = int'(COL_COUNT_RESET);
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one row at the reset column count, a stray final flag mid-row
        for (int c = 0; c < 15; c++)
            send_sample((c % 3 == 0) ? S_MAX : (c % 3 == 1) ? S_MIN : SAMPLE_BITS'(c),
                        (c == 3) || (c == 14));

        // column count zero acts as one; negative means truncate toward zero
        write_columns('0);
        send_sample(S_MAX, 1'b0);
        send_sample(S_MAX, 1'b1);
        send_sample(-24'sd5, 1'b0);
        send_sample('0, 1'b1);
        send_sample(S_MIN, 1'b1);

        // final flag ignored on an element that does not end the row
        write_columns(col_count_t'(2));
        send_sample(S_MAX, 1'b1);
        send_sample(S_MIN, 1'b0);
        send_sample(24'sd7, 1'b0);
        send_sample(-24'sd7, 1'b1);

        // shrink the column count in the middle of a row
        write_columns(col_count_t'(4));
        send_sample(24'sd100, 1'b1);
        send_sample(24'sd200, 1'b0);
        send_sample(24'sd300, 1'b0);
        write_columns(col_count_t'(2));
        send_sample(24'sd400, 1'b1);

        run_phase(32, 47, col_count_t'(31));
        run_phase(47, 32, col_count_t'(MAX_COLS));
        run_phase(0, 0, col_count_t'(1));

        wait_idle(END_WAIT);
        if (fail_count == 0 && pend_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
